@@ src/pid_distance_to_pwm_top_defines.svh @@
// Assertion macros of the PID distance to PWM block checker
`ifndef PID_DISTANCE_TO_PWM_TOP_DEFINES_SVH
`define PID_DISTANCE_TO_PWM_TOP_DEFINES_SVH

// Clocked assertion, masked while reset is held
`define PDP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define PDP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ src/pdp_pkg.sv @@
// Types, codes and constants shared by the PID distance to PWM block
`timescale 1ns / 1ps
package pdp_pkg;

  localparam int unsigned CfgAddrW  = 3;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned DebounceMs = 20;
  localparam int unsigned MsPerS    = 1000;
  localparam int unsigned FracBits  = 30;
  localparam int unsigned DivSteps  = 64;
  localparam int unsigned DivCntW   = $clog2(DivSteps);
  localparam int unsigned RcpSteps  = 4;
  localparam logic [63:0] TermMax   = 64'h2000_0000_0000_0000;

  // ceil(2^68 / 125): x / 1000 is ((x >> 3) * RecipMul) >> 68 for x up to 2^64
  localparam logic [61:0] RecipMul  = 62'(((69'd1 << 68) + 69'd124) / 69'd125);

  localparam logic signed [31:0] GainPRst     = -32'sd107374;
  localparam logic signed [31:0] GainIRst     = -32'sd10737;
  localparam logic signed [31:0] GainDRst     = -32'sd10737;
  localparam logic [15:0]        TargetFarRst  = 16'd400;
  localparam logic [15:0]        TargetNearRst = 16'd200;
  localparam logic [30:0]        LimitRst      = 31'd322122547;
  localparam logic signed [31:0] BiasRst       = 32'sd654982513;
  localparam logic [15:0]        PwmTopRst     = 16'd1000;

  // Configuration register indexes
  typedef enum logic [CfgAddrW-1:0] {
    REG_GAIN_P,
    REG_GAIN_I,
    REG_GAIN_D,
    REG_TARGET_FAR,
    REG_TARGET_NEAR,
    REG_OUTPUT_LIMIT,
    REG_DUTY_BIAS,
    REG_PWM_TOP
  } reg_idx_e;

  typedef struct packed {
    logic signed [31:0] gain_p;
    logic signed [31:0] gain_i;
    logic signed [31:0] gain_d;
    logic [15:0]        target_far;
    logic [15:0]        target_near;
    logic [30:0]        output_limit;
    logic signed [31:0] duty_bias;
    logic [15:0]        pwm_top;
  } cfg_t;

  // Operand set for the shared multiplier
  typedef enum logic [1:0] {
    SEL_SUM,
    SEL_P,
    SEL_I,
    SEL_D
  } sel_e;

  // Datapath operations
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_TERM,
    OP_SUM_ADD,
    OP_ACC,
    OP_RCP_INIT,
    OP_RCP_STEP,
    OP_RCP_DONE,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_DONE,
    OP_CLAMP,
    OP_BUTTON,
    OP_CMP,
    OP_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    sel_e   sel;
  } dp_cmd_t;

  typedef struct packed {
    logic in_button;
  } dp_stat_t;

endpackage

@@ src/pdp_regs.sv @@
// Configuration register bank of the PID distance to PWM block
`timescale 1ns / 1ps
module pdp_regs (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [pdp_pkg::CfgAddrW-1:0]         cfg_addr_i,
  input  logic [pdp_pkg::CfgDataW-1:0]         cfg_wdata_i,
  output pdp_pkg::cfg_t                        cfg_o
);
  import pdp_pkg::*;

  cfg_t cfg_q;

  // Write one register per request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p       <= GainPRst;
      cfg_q.gain_i       <= GainIRst;
      cfg_q.gain_d       <= GainDRst;
      cfg_q.target_far   <= TargetFarRst;
      cfg_q.target_near  <= TargetNearRst;
      cfg_q.output_limit <= LimitRst;
      cfg_q.duty_bias    <= BiasRst;
      cfg_q.pwm_top      <= PwmTopRst;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_addr_i))
        REG_GAIN_P:       cfg_q.gain_p       <= cfg_wdata_i;
        REG_GAIN_I:       cfg_q.gain_i       <= cfg_wdata_i;
        REG_GAIN_D:       cfg_q.gain_d       <= cfg_wdata_i;
        REG_TARGET_FAR:   cfg_q.target_far   <= cfg_wdata_i[15:0];
        REG_TARGET_NEAR:  cfg_q.target_near  <= cfg_wdata_i[15:0];
        REG_OUTPUT_LIMIT: cfg_q.output_limit <= cfg_wdata_i[30:0];
        REG_DUTY_BIAS:    cfg_q.duty_bias    <= cfg_wdata_i;
        REG_PWM_TOP:      cfg_q.pwm_top      <= cfg_wdata_i[15:0];
        default:          cfg_q <= cfg_q;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ src/pdp_ctrl.sv @@
// Sequencing state machine of the PID distance to PWM block
`timescale 1ns / 1ps
module pdp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  logic              m_ready_i,
  output logic              m_valid_o,
  input  pdp_pkg::dp_stat_t stat_i,
  output pdp_pkg::dp_cmd_t  cmd_o
);
  import pdp_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_TERM,
    ST_ACC,
    ST_RCP_INIT,
    ST_RCP_STEP,
    ST_RCP_DONE,
    ST_DIV_INIT,
    ST_DIV_STEP,
    ST_DIV_DONE,
    ST_CLAMP,
    ST_BUTTON,
    ST_CMP,
    ST_OUT
  } state_e;

  state_e             state_q;
  sel_e               sel_q;
  logic [DivCntW-1:0] cnt_q;
  logic               m_valid_q;
  logic               out_free;

  assign out_free = !m_valid_q || m_ready_i;

  // Hold state, operand select, step count and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      sel_q     <= SEL_SUM;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      // Raise the result valid on the last step, drop it once taken
      if (state_q == ST_OUT && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_valid_i) begin
            sel_q   <= SEL_SUM;
            state_q <= stat_i.in_button ? ST_BUTTON : ST_MUL_LO;
          end
        end
        ST_MUL_LO: state_q <= ST_MUL_HI;
        ST_MUL_HI: state_q <= ST_TERM;
        ST_TERM:   state_q <= ST_ACC;
        ST_ACC: begin
          case (sel_q)
            SEL_SUM: begin
              sel_q   <= SEL_I;
              state_q <= ST_RCP_INIT;
            end
            SEL_P: begin
              sel_q   <= SEL_I;
              state_q <= ST_MUL_LO;
            end
            SEL_I: begin
              sel_q   <= SEL_D;
              state_q <= ST_MUL_LO;
            end
            default: state_q <= ST_CLAMP;
          endcase
        end
        ST_RCP_INIT: begin
          cnt_q   <= '0;
          state_q <= ST_RCP_STEP;
        end
        ST_RCP_STEP: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == DivCntW'(RcpSteps - 1)) begin
            state_q <= ST_RCP_DONE;
          end
        end
        ST_RCP_DONE: begin
          sel_q   <= SEL_D;
          state_q <= ST_DIV_INIT;
        end
        ST_DIV_INIT: begin
          cnt_q   <= '0;
          state_q <= ST_DIV_STEP;
        end
        ST_DIV_STEP: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == DivCntW'(DivSteps - 1)) begin
            state_q <= ST_DIV_DONE;
          end
        end
        ST_DIV_DONE: begin
          sel_q   <= SEL_P;
          state_q <= ST_MUL_LO;
        end
        ST_CLAMP:  state_q <= ST_CMP;
        ST_BUTTON: state_q <= ST_CMP;
        ST_CMP:    state_q <= ST_OUT;
        ST_OUT: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Decode the datapath operation of each state
  always_comb begin
    cmd_o.sel = sel_q;
    cmd_o.op  = OP_NONE;
    case (state_q)
      ST_IDLE:     cmd_o.op = s_valid_i ? OP_LOAD : OP_NONE;
      ST_MUL_LO:   cmd_o.op = OP_MUL_LO;
      ST_MUL_HI:   cmd_o.op = OP_MUL_HI;
      ST_TERM:     cmd_o.op = OP_TERM;
      ST_ACC:      cmd_o.op = (sel_q == SEL_SUM) ? OP_SUM_ADD : OP_ACC;
      ST_RCP_INIT: cmd_o.op = OP_RCP_INIT;
      ST_RCP_STEP: cmd_o.op = OP_RCP_STEP;
      ST_RCP_DONE: cmd_o.op = OP_RCP_DONE;
      ST_DIV_INIT: cmd_o.op = OP_DIV_INIT;
      ST_DIV_STEP: cmd_o.op = OP_DIV_STEP;
      ST_DIV_DONE: cmd_o.op = OP_DIV_DONE;
      ST_CLAMP:    cmd_o.op = OP_CLAMP;
      ST_BUTTON:   cmd_o.op = OP_BUTTON;
      ST_CMP:      cmd_o.op = OP_CMP;
      ST_OUT:      cmd_o.op = out_free ? OP_OUT : OP_NONE;
      default:     cmd_o.op = OP_NONE;
    endcase
  end

  assign s_ready_o = (state_q == ST_IDLE);
  assign m_valid_o = m_valid_q;

endmodule

@@ src/pdp_dp.sv @@
// Datapath of the PID distance to PWM block: state, multiplier, divider
`timescale 1ns / 1ps
module pdp_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pdp_pkg::dp_cmd_t   cmd_i,
  output pdp_pkg::dp_stat_t  stat_o,
  input  pdp_pkg::cfg_t      cfg_i,
  input  logic               op_i,
  input  logic [15:0]        dist_i,
  input  logic [31:0]        time_i,
  output logic [15:0]        compare_o,
  output logic signed [31:0] control_o,
  output logic [15:0]        target_o,
  output logic               press_o
);
  import pdp_pkg::*;

  // Controller state kept across requests
  logic signed [63:0] esum_q;
  logic signed [16:0] last_err_q;
  logic [31:0]        last_time_q;
  logic [31:0]        last_press_q;
  logic               near_q;
  logic signed [31:0] held_q;

  // Per-request working registers
  logic signed [16:0] err_q;
  logic signed [17:0] diff_q;
  logic [31:0]        dt_q;
  logic [31:0]        now_q;
  logic               press_q;
  logic [63:0]        plo_q;
  logic [63:0]        phi_q;
  logic signed [63:0] term_q;
  logic signed [63:0] pid_q;
  logic [31:0]        rem_q;
  logic [63:0]        quo_q;
  logic               div_neg_q;
  logic [60:0]        rcp_y_q;
  logic [1:0]         rcp_k_q;
  logic [123:0]       rcp_acc_q;
  logic signed [54:0] qi_q;
  logic signed [28:0] deriv_q;
  logic signed [49:0] v_q;

  // Result register
  logic [15:0]        cmp_out_q;
  logic signed [31:0] ctl_out_q;
  logic [15:0]        tgt_out_q;
  logic               press_out_q;

  logic [15:0]        target;
  logic signed [16:0] err_new;
  logic signed [31:0] g_s;
  logic signed [63:0] q_s;
  logic [31:0]        mg;
  logic [63:0]        mq;
  logic               neg;
  logic [31:0]        mul_b;
  logic [63:0]        prod;
  logic [95:0]        full;
  logic [63:0]        mag;
  logic signed [64:0] esum_sum;
  logic [63:0]        esum_mag;
  logic [31:0]        rcp_a;
  logic [31:0]        rcp_b;
  logic [63:0]        rcp_prod;
  logic [123:0]       rcp_add;
  logic signed [27:0] dk;
  logic [31:0]        den;
  logic [32:0]        rem_sh;
  logic               ge;
  logic [32:0]        rem_sub;
  logic signed [63:0] lim;
  logic signed [32:0] duty;
  logic [19:0]        cmp_raw;
  logic [15:0]        cmp_val;

  assign target  = near_q ? cfg_i.target_near : cfg_i.target_far;
  assign err_new = $signed({1'b0, target}) - $signed({1'b0, dist_i});
  assign stat_o.in_button = op_i;

  // Pick gain and operand for the shared multiplier
  always_comb begin
    case (cmd_i.sel)
      SEL_SUM: begin
        g_s = {{15{err_q[16]}}, err_q};
        q_s = {32'd0, dt_q};
      end
      SEL_P: begin
        g_s = cfg_i.gain_p;
        q_s = {{47{err_q[16]}}, err_q};
      end
      SEL_I: begin
        g_s = cfg_i.gain_i;
        q_s = {{9{qi_q[54]}}, qi_q};
      end
      default: begin
        g_s = cfg_i.gain_d;
        q_s = {{35{deriv_q[28]}}, deriv_q};
      end
    endcase
  end

  // Sign and magnitude, one 32 by 32 product per cycle
  assign mg    = g_s[31] ? (32'd0 - g_s) : g_s;
  assign mq    = q_s[63] ? (64'd0 - q_s) : q_s;
  assign neg   = g_s[31] ^ q_s[63];
  assign mul_b = (cmd_i.op == OP_MUL_HI) ? mq[63:32] : mq[31:0];
  assign prod  = mg * mul_b;

  // Join partial products and saturate the term magnitude
  assign full = {phi_q, 32'd0} + {32'd0, plo_q};
  assign mag  = (full > {32'd0, TermMax}) ? TermMax : full[63:0];

  assign esum_sum = {esum_q[63], esum_q} + {term_q[63], term_q};

  // Integral over 1000: one 32 by 32 partial product of (|sum| >> 3) * RecipMul per step
  assign esum_mag = esum_q[63] ? (64'd0 - esum_q) : esum_q;
  assign rcp_a    = rcp_k_q[0] ? {3'd0, rcp_y_q[60:32]} : rcp_y_q[31:0];
  assign rcp_b    = rcp_k_q[1] ? {2'd0, RecipMul[61:32]} : RecipMul[31:0];
  assign rcp_prod = rcp_a * rcp_b;

  // Align the partial product to its weight
  always_comb begin
    case (rcp_k_q)
      2'd0:       rcp_add = {60'd0, rcp_prod};
      2'd1, 2'd2: rcp_add = {28'd0, rcp_prod, 32'd0};
      default:    rcp_add = {rcp_prod[59:0], 64'd0};
    endcase
  end

  // Divider operands
  assign dk      = {{10{diff_q[17]}}, diff_q} * 28'sd1000;
  assign den     = dt_q;
  assign rem_sh  = {rem_q, quo_q[63]};
  assign ge      = rem_sh >= {1'b0, den};
  assign rem_sub = rem_sh - {1'b0, den};

  assign lim  = $signed({33'd0, cfg_i.output_limit});
  assign duty = {held_q[31], held_q} + {cfg_i.duty_bias[31], cfg_i.duty_bias};

  // Saturate the scaled duty to the compare range
  assign cmp_raw = v_q[49:30];
  always_comb begin
    if (v_q <= 50'sd0) begin
      cmp_val = 16'd0;
    end else if (cmp_raw > {4'd0, cfg_i.pwm_top}) begin
      cmp_val = cfg_i.pwm_top;
    end else begin
      cmp_val = cmp_raw[15:0];
    end
  end

  // Persistent controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esum_q       <= '0;
      last_err_q   <= '0;
      last_time_q  <= '0;
      last_press_q <= '0;
      near_q       <= 1'b0;
      held_q       <= '0;
    end else begin
      case (cmd_i.op)
        OP_SUM_ADD: begin
          if (esum_sum[64] != esum_sum[63]) begin
            esum_q <= esum_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
          end else begin
            esum_q <= esum_sum[63:0];
          end
        end
        OP_CLAMP: begin
          if (pid_q >= lim) begin
            held_q <= lim[31:0];
          end else if (pid_q <= -lim) begin
            held_q <= 32'(-lim);
          end else begin
            held_q <= pid_q[31:0];
          end
          last_err_q  <= err_q;
          last_time_q <= now_q;
        end
        OP_BUTTON: begin
          if ((now_q - last_press_q) > 32'(DebounceMs)) begin
            last_press_q <= now_q;
            near_q       <= !near_q;
          end
        end
        default: ;
      endcase
    end
  end

  // Working registers of one request
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        err_q   <= err_new;
        diff_q  <= {err_new[16], err_new} - {last_err_q[16], last_err_q};
        dt_q    <= time_i - last_time_q;
        now_q   <= time_i;
        press_q <= 1'b0;
        pid_q   <= '0;
      end
      OP_MUL_LO: plo_q <= prod;
      OP_MUL_HI: phi_q <= prod;
      OP_TERM:   term_q <= neg ? (64'sd0 - $signed(mag)) : $signed(mag);
      OP_ACC:    pid_q <= pid_q + term_q;
      OP_RCP_INIT: begin
        rcp_y_q   <= esum_mag[63:3];
        div_neg_q <= esum_q[63];
        rcp_acc_q <= '0;
        rcp_k_q   <= '0;
      end
      OP_RCP_STEP: begin
        rcp_acc_q <= rcp_acc_q + rcp_add;
        rcp_k_q   <= rcp_k_q + 2'd1;
      end
      OP_RCP_DONE: begin
        qi_q <= div_neg_q ? (55'sd0 - $signed(rcp_acc_q[122:68]))
                          : $signed(rcp_acc_q[122:68]);
      end
      OP_DIV_INIT: begin
        rem_q     <= '0;
        quo_q     <= {36'd0, (dk[27] ? (28'd0 - dk) : dk)};
        div_neg_q <= dk[27];
      end
      OP_DIV_STEP: begin
        rem_q <= ge ? rem_sub[31:0] : rem_sh[31:0];
        quo_q <= {quo_q[62:0], ge};
      end
      OP_DIV_DONE: begin
        if (dt_q == 32'd0) begin
          deriv_q <= '0;
        end else begin
          deriv_q <= div_neg_q ? (29'sd0 - $signed(quo_q[28:0])) : $signed(quo_q[28:0]);
        end
      end
      OP_BUTTON: begin
        if ((now_q - last_press_q) > 32'(DebounceMs)) begin
          press_q <= 1'b1;
        end
      end
      OP_CMP: v_q <= duty * $signed({1'b0, cfg_i.pwm_top});
      OP_OUT: begin
        cmp_out_q   <= cmp_val;
        ctl_out_q   <= held_q;
        tgt_out_q   <= target;
        press_out_q <= press_q;
      end
      default: ;
    endcase
  end

  assign compare_o = cmp_out_q;
  assign control_o = ctl_out_q;
  assign target_o  = tgt_out_q;
  assign press_o   = press_out_q;

endmodule

@@ src/pid_distance_to_pwm_top.sv @@
// Top level of the PID distance to PWM block
// Usage:
//   Input stream: s_axis_tuser selects the request kind (0 distance sample,
//   1 button event); s_axis_tdata carries distance and millisecond timestamp.
//   Output stream: one result per request with PWM compare value, clamped
//   PID output, active setpoint and the button accepted flag.
//   Configuration: cfg_we_i writes cfg_wdata_i to register cfg_addr_i;
//   write only while no request is in flight.
//   Sequence: a sample passes through one 64-step shift-subtract division
//   (derivative by elapsed time), a four-step reciprocal multiplication
//   (integral by 1000) and four passes through the shared 32x32
//   multiplier. A button event skips the multiplier and divider steps.
//   Throughput: one request at a time; s_axis_tready is high only while idle.
//   A result held by a stalled receiver stays in the output register; the
//   next request is still accepted and waits at its last step until the
//   register frees.
//   Reset clears the integral, history, setpoint choice and held output and
//   loads the register defaults; no clearing pass is needed.
`timescale 1ns / 1ps
module pid_distance_to_pwm_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [47:0]                  s_axis_tdata,  // distance_mm, time_ms
  input  logic                         s_axis_tuser,  // operation
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // compare_value, control_value, active_target, press_accepted, zero pad
  output logic [71:0]                  m_axis_tdata,
  input  logic                         cfg_we_i,
  input  logic [pdp_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [pdp_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import pdp_pkg::*;

  cfg_t               cfg;
  dp_cmd_t            cmd;
  dp_stat_t           stat;
  logic [15:0]        compare_value;
  logic signed [31:0] control_value;
  logic [15:0]        active_target;
  logic               press_accepted;

  pdp_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  pdp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_ready_i (m_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  pdp_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .cfg_i     (cfg),
    .op_i      (s_axis_tuser),
    .dist_i    (s_axis_tdata[15:0]),
    .time_i    (s_axis_tdata[47:16]),
    .compare_o (compare_value),
    .control_o (control_value),
    .target_o  (active_target),
    .press_o   (press_accepted)
  );

  // Pack the result fields, lowest first
  assign m_axis_tdata = {7'd0, press_accepted, active_target, control_value, compare_value};

endmodule

@@ src/pdp_checker.sv @@
// Port-level assertions for the PID distance to PWM block, bound to the top
`timescale 1ns / 1ps
`include "pid_distance_to_pwm_top_defines.svh"
module pdp_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready
);

  // A pending result stays offered until taken
  `PDP_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped")

  // No result is offered while reset is held
  `PDP_ASSERT_RST(a_rst_quiet, !rst_ni |-> !m_axis_tvalid, "result during reset")

  // An accepted request makes the block busy
  `PDP_ASSERT(a_busy, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "ready after request")

  // A result never appears the cycle after acceptance
  `PDP_ASSERT(a_no_early, s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid), "early result")

endmodule

bind pid_distance_to_pwm_top pdp_checker u_pdp_checker (.*);
